// ===== sv/pdd_pkg.sv =====
// Shared types, constants and fixed-point helpers for the deadband PID block.
// No dependencies; used by every module of the block.
package pdd_pkg;

   localparam int unsigned PROD_W = 67;

   localparam logic signed [32:0] DECAY_Q16 = 33'sd64225;
   localparam logic [16:0]        ONE_Q16   = 17'd65536;

   localparam logic [2:0] REG_KP        = 3'd0;
   localparam logic [2:0] REG_KI        = 3'd1;
   localparam logic [2:0] REG_KD        = 3'd2;
   localparam logic [2:0] REG_OUT_LIM   = 3'd3;
   localparam logic [2:0] REG_INT_LIM   = 3'd4;
   localparam logic [2:0] REG_DEAD_ZONE = 3'd5;
   localparam logic [2:0] REG_SEP_LIM   = 3'd6;
   localparam logic [2:0] REG_ALPHA     = 3'd7;

   typedef struct packed {
      logic signed [31:0] kp;
      logic signed [31:0] ki;
      logic signed [31:0] kd;
      logic [30:0]        out_limit;
      logic [30:0]        integral_limit;
      logic [30:0]        dead_zone;
      logic [30:0]        separation_limit;
      logic [16:0]        deriv_alpha;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_ERR,
      OP_P_MUL, OP_P_INT, OP_P_DEC, OP_D_INT, OP_D_DEC, OP_DN,
      OP_BA, OP_BB, OP_BS, OP_SUM,
      OP_I_MP, OP_I_MI, OP_I_BA, OP_I_BB, OP_I_BS, OP_I_MD, OP_I_DD, OP_I_SUM
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load_rsp;
   } cmd_type;

   typedef struct packed {
      logic sep_hit;
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PMUL, ST_PINT, ST_PDER, ST_PDN, ST_PBA, ST_PBB, ST_PBS, ST_PSUM,
      ST_IMP, ST_IMI, ST_IBA, ST_IBB, ST_IBS, ST_IMD, ST_IDD, ST_ISUM,
      ST_WB
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Shift a wide product right toward zero and saturate to 32 bits
   function automatic logic signed [31:0] settle(input logic signed [PROD_W-1:0] v,
                                                 input logic [4:0] sh);
      logic [PROD_W-1:0]  mag;
      logic [PROD_W-1:0]  shifted;
      logic signed [31:0] r;
      mag     = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
      shifted = mag >> sh;
      if (!v[PROD_W-1]) begin
         r = (|shifted[PROD_W-1:31]) ? 32'sh7FFF_FFFF : shifted[31:0];
      end else if (shifted > PROD_W'(33'h0_8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = -shifted[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clampsym(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
      logic signed [32:0] lim33;
      logic signed [32:0] v33;
      logic signed [31:0] r;
      lim33 = {2'b00, lim};
      v33   = {v[31], v};
      if (v33 > lim33) begin
         r = {1'b0, lim};
      end else if (v33 < -lim33) begin
         r = -{1'b0, lim};
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== sv/pdd_csr.sv =====
// Configuration register bank for the deadband PID block.
// Depends on pdd_pkg for the register indexes and the cfg_type bundle.
module pdd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [31:0]      csr_wdata,
   output pdd_pkg::cfg_type cfg
);

   pdd_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp               <= '0;
         cfg_ff.ki               <= '0;
         cfg_ff.kd               <= '0;
         cfg_ff.out_limit        <= 31'h7FFF_FFFF;
         cfg_ff.integral_limit   <= 31'h7FFF_FFFF;
         cfg_ff.dead_zone        <= '0;
         cfg_ff.separation_limit <= '0;
         cfg_ff.deriv_alpha      <= pdd_pkg::ONE_Q16;
      end else if (csr_we) begin
         case (csr_addr)
            pdd_pkg::REG_KP:        cfg_ff.kp               <= csr_wdata;
            pdd_pkg::REG_KI:        cfg_ff.ki               <= csr_wdata;
            pdd_pkg::REG_KD:        cfg_ff.kd               <= csr_wdata;
            pdd_pkg::REG_OUT_LIM:   cfg_ff.out_limit        <= csr_wdata[30:0];
            pdd_pkg::REG_INT_LIM:   cfg_ff.integral_limit   <= csr_wdata[30:0];
            pdd_pkg::REG_DEAD_ZONE: cfg_ff.dead_zone        <= csr_wdata[30:0];
            pdd_pkg::REG_SEP_LIM:   cfg_ff.separation_limit <= csr_wdata[30:0];
            pdd_pkg::REG_ALPHA:     cfg_ff.deriv_alpha      <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/pdd_dp.sv =====
// Datapath of the deadband PID block: error stage, shared multiplier, state.
// Depends on pdd_pkg for ops, status, configuration and fixed-point helpers.
module pdd_dp (
   input  logic               clock,
   input  logic               reset,
   input  pdd_pkg::cfg_type   cfg,
   input  pdd_pkg::cmd_type   cmd,
   input  logic signed [31:0] setpoint,
   input  logic signed [31:0] feedback,
   output pdd_pkg::status_type status,
   output logic signed [31:0] drive
);

   logic signed [31:0] err_now_ff, err_prev_ff, err_prev2_ff;
   logic signed [31:0] integral_ff, diff_ff, last_d_ff, out_ff;
   logic signed [31:0] p_ff, i_ff, dn_ff;
   logic signed [pdd_pkg::PROD_W-1:0] prod_ff, acc_ff;
   logic signed [31:0] drive_ff;

   logic signed [32:0] raw;
   logic [32:0]        raw_mag;
   logic signed [31:0] err_new;
   logic [31:0]        err_mag;
   logic [16:0]        alpha_eff;
   logic [16:0]        beta;
   logic signed [32:0] err_sum, err_dif;
   logic signed [33:0] en34, ep34, ep2_34, diff2;
   logic signed [32:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [pdd_pkg::PROD_W-1:0] blend_sum;

   function automatic logic signed [32:0] p_sext(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

   always_comb begin
      raw     = {setpoint[31], setpoint} - {feedback[31], feedback};
      raw_mag = raw[32] ? 33'(-raw) : 33'(raw);
      err_new = (raw_mag < {2'b00, cfg.dead_zone}) ? 32'sd0 : pdd_pkg::sat32({raw[32], raw});
      err_mag = err_now_ff[31] ? 32'(-err_now_ff) : 32'(err_now_ff);
      status.sep_hit = (cfg.separation_limit != '0) && (err_mag >= {1'b0, cfg.separation_limit});

      alpha_eff = (cfg.deriv_alpha > pdd_pkg::ONE_Q16) ? pdd_pkg::ONE_Q16 : cfg.deriv_alpha;
      beta      = pdd_pkg::ONE_Q16 - alpha_eff;

      err_sum = {err_now_ff[31], err_now_ff} + {err_prev_ff[31], err_prev_ff};
      err_dif = {err_now_ff[31], err_now_ff} - {err_prev_ff[31], err_prev_ff};
      en34    = {{2{err_now_ff[31]}}, err_now_ff};
      ep34    = {{2{err_prev_ff[31]}}, err_prev_ff};
      ep2_34  = {{2{err_prev2_ff[31]}}, err_prev2_ff};
      diff2   = en34 - (ep34 <<< 1) + ep2_34;

      blend_sum = acc_ff + prod_ff;

      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         pdd_pkg::OP_P_MUL: begin
            mul_a = {p_sext(cfg.kp)};
            mul_b = en34;
         end
         pdd_pkg::OP_P_INT: begin
            mul_a = p_sext(cfg.ki);
            mul_b = {err_sum[32], err_sum};
         end
         pdd_pkg::OP_P_DEC: begin
            mul_a = pdd_pkg::DECAY_Q16;
            mul_b = {{2{integral_ff[31]}}, integral_ff};
         end
         pdd_pkg::OP_D_INT, pdd_pkg::OP_D_DEC, pdd_pkg::OP_I_MD: begin
            mul_a = p_sext(cfg.kd);
            mul_b = {{2{diff_ff[31]}}, diff_ff};
         end
         pdd_pkg::OP_BA: begin
            mul_a = {16'd0, alpha_eff};
            mul_b = {{2{dn_ff[31]}}, dn_ff};
         end
         pdd_pkg::OP_BB: begin
            mul_a = {16'd0, beta};
            mul_b = {{2{last_d_ff[31]}}, last_d_ff};
         end
         pdd_pkg::OP_I_MP: begin
            mul_a = p_sext(cfg.kp);
            mul_b = {err_dif[32], err_dif};
         end
         pdd_pkg::OP_I_MI: begin
            mul_a = p_sext(cfg.ki);
            mul_b = en34;
         end
         pdd_pkg::OP_I_BA: begin
            mul_a = {16'd0, alpha_eff};
            mul_b = diff2;
         end
         pdd_pkg::OP_I_BB: begin
            mul_a = {16'd0, beta};
            mul_b = {{2{diff_ff[31]}}, diff_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load_rsp) begin
         drive_ff <= out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_now_ff   <= '0;
         err_prev_ff  <= '0;
         err_prev2_ff <= '0;
         integral_ff  <= '0;
         diff_ff      <= '0;
         last_d_ff    <= '0;
         out_ff       <= '0;
         p_ff         <= '0;
         i_ff         <= '0;
         dn_ff        <= '0;
         acc_ff       <= '0;
      end else begin
         case (cmd.op)
            pdd_pkg::OP_CLEAR: begin
               err_now_ff   <= '0;
               err_prev_ff  <= '0;
               err_prev2_ff <= '0;
               integral_ff  <= '0;
               diff_ff      <= '0;
               last_d_ff    <= '0;
               out_ff       <= '0;
            end
            pdd_pkg::OP_ERR: begin
               err_prev2_ff <= err_prev_ff;
               err_prev_ff  <= err_now_ff;
               err_now_ff   <= err_new;
            end
            pdd_pkg::OP_P_INT, pdd_pkg::OP_P_DEC: begin
               p_ff    <= pdd_pkg::settle(prod_ff, 5'd16);
               diff_ff <= pdd_pkg::sat32({err_dif[32], err_dif});
            end
            pdd_pkg::OP_D_INT: begin
               integral_ff <= pdd_pkg::sat32({{2{integral_ff[31]}}, integral_ff}
                  + 34'(pdd_pkg::settle(prod_ff, 5'd17)));
            end
            pdd_pkg::OP_D_DEC: begin
               integral_ff <= pdd_pkg::settle(prod_ff, 5'd16);
            end
            pdd_pkg::OP_DN: begin
               dn_ff       <= pdd_pkg::settle(prod_ff, 5'd16);
               integral_ff <= pdd_pkg::clampsym(integral_ff, cfg.integral_limit);
            end
            pdd_pkg::OP_BB, pdd_pkg::OP_I_BB: begin
               acc_ff <= prod_ff;
            end
            pdd_pkg::OP_BS: begin
               last_d_ff <= pdd_pkg::settle(blend_sum, 5'd16);
            end
            pdd_pkg::OP_SUM: begin
               out_ff <= pdd_pkg::clampsym(pdd_pkg::sat32({{2{p_ff[31]}}, p_ff}
                  + {{2{integral_ff[31]}}, integral_ff}
                  + {{2{last_d_ff[31]}}, last_d_ff}), cfg.out_limit);
            end
            pdd_pkg::OP_I_MI: begin
               p_ff <= pdd_pkg::settle(prod_ff, 5'd16);
            end
            pdd_pkg::OP_I_BA: begin
               i_ff <= pdd_pkg::settle(prod_ff, 5'd16);
            end
            pdd_pkg::OP_I_BS: begin
               diff_ff <= pdd_pkg::settle(blend_sum, 5'd16);
            end
            pdd_pkg::OP_I_DD: begin
               dn_ff <= pdd_pkg::settle(prod_ff, 5'd16);
            end
            pdd_pkg::OP_I_SUM: begin
               out_ff <= pdd_pkg::clampsym(pdd_pkg::sat32({{2{out_ff[31]}}, out_ff}
                  + {{2{p_ff[31]}}, p_ff} + {{2{i_ff[31]}}, i_ff}
                  + {{2{dn_ff[31]}}, dn_ff}), cfg.out_limit);
            end
            default: ;
         endcase
      end
   end

   assign drive = drive_ff;

endmodule

// ===== sv/pdd_ctrl.sv =====
// Sequencer of the deadband PID block: handshakes and the per-step op sequence.
// Depends on pdd_pkg for states, ops and the command and status bundles.
module pdd_ctrl #(
   parameter int MODE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_cmd,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pdd_pkg::status_type  status,
   output pdd_pkg::cmd_type     cmd
);

   localparam logic INCR = (MODE != 0);

   pdd_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = pdd_pkg::OP_NONE;
      cmd.load_rsp = 1'b0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         pdd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_cmd) begin
                  cmd.op   = pdd_pkg::OP_CLEAR;
                  state_in = pdd_pkg::ST_WB;
               end else begin
                  cmd.op   = pdd_pkg::OP_ERR;
                  state_in = INCR ? pdd_pkg::ST_IMP : pdd_pkg::ST_PMUL;
               end
            end
         end
         pdd_pkg::ST_PMUL: begin
            cmd.op   = pdd_pkg::OP_P_MUL;
            state_in = pdd_pkg::ST_PINT;
         end
         pdd_pkg::ST_PINT: begin
            // decay instead of integrating when the error is too large
            cmd.op   = status.sep_hit ? pdd_pkg::OP_P_DEC : pdd_pkg::OP_P_INT;
            state_in = pdd_pkg::ST_PDER;
         end
         pdd_pkg::ST_PDER: begin
            cmd.op   = status.sep_hit ? pdd_pkg::OP_D_DEC : pdd_pkg::OP_D_INT;
            state_in = pdd_pkg::ST_PDN;
         end
         pdd_pkg::ST_PDN: begin
            cmd.op   = pdd_pkg::OP_DN;
            state_in = pdd_pkg::ST_PBA;
         end
         pdd_pkg::ST_PBA: begin
            cmd.op   = pdd_pkg::OP_BA;
            state_in = pdd_pkg::ST_PBB;
         end
         pdd_pkg::ST_PBB: begin
            cmd.op   = pdd_pkg::OP_BB;
            state_in = pdd_pkg::ST_PBS;
         end
         pdd_pkg::ST_PBS: begin
            cmd.op   = pdd_pkg::OP_BS;
            state_in = pdd_pkg::ST_PSUM;
         end
         pdd_pkg::ST_PSUM: begin
            cmd.op   = pdd_pkg::OP_SUM;
            state_in = pdd_pkg::ST_WB;
         end
         pdd_pkg::ST_IMP: begin
            cmd.op   = pdd_pkg::OP_I_MP;
            state_in = pdd_pkg::ST_IMI;
         end
         pdd_pkg::ST_IMI: begin
            cmd.op   = pdd_pkg::OP_I_MI;
            state_in = pdd_pkg::ST_IBA;
         end
         pdd_pkg::ST_IBA: begin
            cmd.op   = pdd_pkg::OP_I_BA;
            state_in = pdd_pkg::ST_IBB;
         end
         pdd_pkg::ST_IBB: begin
            cmd.op   = pdd_pkg::OP_I_BB;
            state_in = pdd_pkg::ST_IBS;
         end
         pdd_pkg::ST_IBS: begin
            cmd.op   = pdd_pkg::OP_I_BS;
            state_in = pdd_pkg::ST_IMD;
         end
         pdd_pkg::ST_IMD: begin
            cmd.op   = pdd_pkg::OP_I_MD;
            state_in = pdd_pkg::ST_IDD;
         end
         pdd_pkg::ST_IDD: begin
            cmd.op   = pdd_pkg::OP_I_DD;
            state_in = pdd_pkg::ST_ISUM;
         end
         pdd_pkg::ST_ISUM: begin
            cmd.op   = pdd_pkg::OP_I_SUM;
            state_in = pdd_pkg::ST_WB;
         end
         pdd_pkg::ST_WB: begin
            // hold until the output register is free or drains this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pdd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/pid_deadband_dfilter.sv =====
// Fixed-point PID controller with deadband, integral separation and a filtered
// derivative. Each accepted request yields one drive value. A control step runs
// through one shared 33x34-bit multiplier with a register after it, in
// positional mode (MODE 0) and in incremental mode alike, as a sequence of
// multiply and update states followed by the load of the output register; a
// clear request goes straight to the load of the output register. Requests are
// taken one at a time, and the next one is accepted while the previous result
// still sits in the output register; a stalled result holds the following step
// in its write-back state. Configuration writes are applied at once and should
// be made while idle.
module pid_deadband_dfilter #(
   parameter int MODE = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] setpoint, [63:32] feedback
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] drive
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   pdd_pkg::cfg_type    cfg;
   pdd_pkg::cmd_type    cmd;
   pdd_pkg::status_type status;
   logic signed [31:0]  drive;

   pdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pdd_ctrl #(.MODE(MODE)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pdd_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .setpoint (req_tdata[31:0]),
      .feedback (req_tdata[63:32]),
      .status   (status),
      .drive    (drive)
   );

   assign rsp_tdata = drive;

endmodule
